>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by slot_ordered_completion_queue.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/socq_pkg.sv
// ---------------------------------------------------------------------------
// socq_pkg
// Types and constants of the slot ordered completion queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package socq_pkg;

    localparam int SLOT_BITS = 16;
    localparam int MS_BITS   = 32;
    localparam int OCC_BITS  = 5;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_REPLY   = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED    = 2'd0,
        ST_FULL        = 2'd1,
        ST_COMPLETED   = 2'd2,
        ST_UNSOLICITED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_POP_A,
        S_POP_B,
        S_POP_C,
        S_EMIT
    } t_state;

    // Wrap-aware order: a is before b when the 16-bit difference is negative.
    function automatic logic earlier_slot(input logic [SLOT_BITS-1:0] a,
                                          input logic [SLOT_BITS-1:0] b);
        logic [SLOT_BITS-1:0] diff;
        diff = a - b;
        return diff[SLOT_BITS-1];
    endfunction

endpackage

>>> design/socq_ram.sv
// ---------------------------------------------------------------------------
// socq_ram
// Generic RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module socq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/slot_ordered_completion_queue.sv
// ---------------------------------------------------------------------------
// slot_ordered_completion_queue
// Queue of outstanding requests kept in wrap-aware ring slot order, with
// the front entry's timeout reported whenever the front changes.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      i_in_valid/o_in_stall   command, slot, ordered, tag, ms
//  out      output     o_out_valid/i_out_stall status, tags, arm, occupancy
//
// An ordered enqueue scans the queue and then shifts the later entries up
// one place; both walk the single read and write port of the entry RAM,
// before the insert and result steps. An append goes straight to the insert
// step, a reply through the pop steps, a refused enqueue or an unsolicited
// reply straight to the result step. Reset is synchronous and empties the
// queue at once, with no clearing pass. A result still waiting in the output
// register holds the next item in its last step until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module slot_ordered_completion_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic [socq_pkg::SLOT_BITS-1:0]   i_ring_slot,
    input  logic                             i_is_ordered,
    input  logic [TAG_BITS-1:0]              i_request_tag,
    input  logic [socq_pkg::MS_BITS-1:0]     i_deadline_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_status,
    output logic [TAG_BITS-1:0]              o_done_tag,
    output logic                             o_arm_timer,
    output logic [TAG_BITS-1:0]              o_arm_tag,
    output logic [socq_pkg::MS_BITS-1:0]     o_arm_ms,
    output logic [socq_pkg::OCC_BITS-1:0]    o_occupancy
);

    import socq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = SLOT_BITS + 1 + TAG_BITS + MS_BITS;

    // Physical RAM address of a logical queue position.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic          r_out_valid, n_out_valid;

    // Item being worked on.
    logic                 r_cmd, r_ord;
    logic [SLOT_BITS-1:0] r_slot;
    logic [TAG_BITS-1:0]  r_tag;
    logic [MS_BITS-1:0]   r_ms;

    // Sequencer working registers.
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_dst, n_dst;
    logic          r_pend, n_pend;
    logic          r_more, n_more;

    // Result being built, and the output register.
    t_status              r_status, n_status;
    logic [TAG_BITS-1:0]  r_done, n_done;
    logic                 r_arm, n_arm;
    logic [TAG_BITS-1:0]  r_arm_tag, n_arm_tag;
    logic [MS_BITS-1:0]   r_arm_ms, n_arm_ms;

    t_status              r_out_status;
    logic [TAG_BITS-1:0]  r_out_done, r_out_arm_tag;
    logic                 r_out_arm;
    logic [MS_BITS-1:0]   r_out_arm_ms;
    logic [OCC_BITS-1:0]  r_out_occ;

    logic          accept, load_out;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [SLOT_BITS-1:0] e_slot;
    logic                 e_ord;
    logic [TAG_BITS-1:0]  e_tag;
    logic [MS_BITS-1:0]   e_ms;
    logic                 hit, scan_hit, scan_end;

    assign e_slot = ram_rdata[EW-1 -: SLOT_BITS];
    assign e_ord  = ram_rdata[MS_BITS + TAG_BITS];
    assign e_tag  = ram_rdata[MS_BITS +: TAG_BITS];
    assign e_ms   = ram_rdata[MS_BITS-1:0];

    // The new entry goes before the first unordered or later-slot entry.
    assign hit      = !e_ord || earlier_slot(r_slot, e_slot);
    assign scan_hit = r_pend && hit;
    assign scan_end = r_pend && !hit && (r_idx == r_count);

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign load_out = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    socq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_ENQUEUE) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_state = S_EMIT;
                        end else if (i_is_ordered && (r_count != '0)) begin
                            n_state = S_SCAN;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end else if (r_count == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_POP_A;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_SHIFT;
                end else if (scan_end) begin
                    n_state = S_WRITE;
                end
            end
            S_SHIFT: begin
                if (!r_more && r_pend) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_EMIT;
            S_POP_A: n_state = S_POP_B;
            S_POP_B: n_state = S_POP_C;
            S_POP_C: n_state = S_EMIT;
            S_EMIT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_dst       = r_dst;
        n_pend      = r_pend;
        n_more      = r_more;
        n_status    = r_status;
        n_done      = r_done;
        n_arm       = r_arm;
        n_arm_tag   = r_arm_tag;
        n_arm_ms    = r_arm_ms;
        ram_we      = 1'b0;
        ram_waddr   = phys(r_head, r_dst);
        ram_wdata   = ram_rdata;
        ram_raddr   = phys(r_head, r_idx);
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                n_done    = '0;
                n_arm     = 1'b0;
                n_arm_tag = '0;
                n_arm_ms  = '0;
                n_idx     = '0;
                n_pend    = 1'b0;
                n_pos     = r_count;
                if (i_command == CMD_ENQUEUE) begin
                    n_status = (r_count == CW'(QUEUE_DEPTH)) ? ST_FULL : ST_ENQUEUED;
                end else begin
                    n_status = (r_count == '0) ? ST_UNSOLICITED : ST_COMPLETED;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_pos  = r_idx - CW'(1);
                    n_idx  = r_count - CW'(1);
                    n_more = 1'b1;
                    n_pend = 1'b0;
                end else if (scan_end) begin
                    n_pos = r_count;
                end else begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end
            end
            S_SHIFT: begin
                // Entry read last cycle moves up one place while the next
                // lower entry is read.
                ram_we = r_pend;
                if (r_more) begin
                    n_pend = 1'b1;
                    n_dst  = r_idx + CW'(1);
                    if (r_idx == r_pos) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx - CW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_pos);
                ram_wdata = {r_slot, r_ord, r_tag, r_ms};
                n_count   = r_count + CW'(1);
                if (r_pos == '0) begin
                    n_arm     = 1'b1;
                    n_arm_tag = r_tag;
                    n_arm_ms  = r_ms;
                end
            end
            S_POP_A: begin
                ram_raddr = phys(r_head, CW'(0));
            end
            S_POP_B: begin
                ram_raddr = phys(r_head, CW'(1));
                n_done    = e_tag;
            end
            S_POP_C: begin
                n_head  = phys(r_head, CW'(1));
                n_count = r_count - CW'(1);
                if (r_count != CW'(1)) begin
                    n_arm     = 1'b1;
                    n_arm_tag = e_tag;
                    n_arm_ms  = e_ms;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_slot <= i_ring_slot;
            r_ord  <= i_is_ordered;
            r_tag  <= i_request_tag;
            r_ms   <= i_deadline_ms;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_dst     <= n_dst;
        r_pend    <= n_pend;
        r_more    <= n_more;
        r_status  <= n_status;
        r_done    <= n_done;
        r_arm     <= n_arm;
        r_arm_tag <= n_arm_tag;
        r_arm_ms  <= n_arm_ms;
        if (load_out) begin
            r_out_status  <= r_status;
            r_out_done    <= r_done;
            r_out_arm     <= r_arm;
            r_out_arm_tag <= r_arm_tag;
            r_out_arm_ms  <= r_arm_ms;
            r_out_occ     <= OCC_BITS'(r_count);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_done_tag  = r_out_done;
    assign o_arm_timer = r_out_arm;
    assign o_arm_tag   = r_out_arm_tag;
    assign o_arm_ms    = r_out_arm_ms;
    assign o_occupancy = r_out_occ;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n,
        r_count > CW'(QUEUE_DEPTH), "queue count above depth")
    `ASSERT_CLK(a_write_grows, i_clk, i_rst_n,
        (r_state == S_WRITE) |=> (r_count == $past(r_count) + CW'(1)),
        "insert did not grow the queue")
    `ASSERT_CLK(a_reply_kind, i_clk, i_rst_n,
        (r_state == S_POP_C) |-> (r_cmd == CMD_REPLY && r_status == ST_COMPLETED),
        "pop without a completing reply")
    `ASSERT_CLK(a_scan_range, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> (r_idx <= r_count && r_ord),
        "scan beyond the queue or for an unordered item")
    `ASSERT_CLK(a_no_arm_refused, i_clk, i_rst_n,
        (o_out_valid && (o_status == ST_FULL || o_status == ST_UNSOLICITED))
            |-> (!o_arm_timer && o_done_tag == '0),
        "refused item reports a tag or arms a timer")

endmodule
